// ===== hdl/motion_tamper_alarm_detector_assert.svh =====
// ----------------------------------------------------------------------------
// Motion tamper alarm detector assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOTION_TAMPER_ALARM_DETECTOR_ASSERT_SVH
`define MOTION_TAMPER_ALARM_DETECTOR_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define MTAD_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("mtad: invariant violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define MTAD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mtad: next-cycle property violated");

`endif

// ===== hdl/mtad_pkg.sv =====
// ----------------------------------------------------------------------------
// mtad_pkg
// Types and constants shared by the motion tamper alarm detector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtad_pkg;

   localparam int unsigned THRESH_BITS    = 12;
   localparam int unsigned LIMIT_BITS     = 8;
   localparam int unsigned SEQ_BITS       = 32;
   localparam int unsigned COUNT_BITS     = 8;
   localparam int unsigned TAMPER_BITS    = 3;
   localparam int unsigned CSR_INDEX_BITS = 8;
   localparam int unsigned CSR_DATA_BITS  = 12;

   localparam logic [TAMPER_BITS-1:0] TAMPER_RELOAD = 3'd5;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = 8'hFF;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOTION_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOSS_LIMIT       = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOVING_LIMIT     = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALARM_BEEP_LIMIT = 8'd3;

   typedef enum logic [1:0] {
      ACK_NONE,
      ACK_ALARM,
      ACK_BROADCAST
   } ack_type;

   typedef enum logic [1:0] {
      SLEEP_WARMUP,
      SLEEP_TAMPER,
      SLEEP_LOSS,
      SLEEP_IDLE
   } sleep_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0] motion_threshold;
      logic [LIMIT_BITS-1:0]  loss_limit;
      logic [LIMIT_BITS-1:0]  moving_limit;
      logic [LIMIT_BITS-1:0]  alarm_beep_limit;
   } cfg_type;

   typedef struct packed {
      logic skip;
      logic warmup_done;
      logic motion;
   } win_status_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0]   packet_seq;
      logic [COUNT_BITS-1:0] packet_moving;
      logic                  use_alarm_address;
      ack_type               ack_outcome;
      logic                  alarm_beep;
      logic                  warmup_done;
      sleep_type             sleep_kind;
      logic [COUNT_BITS-1:0] alarm_count;
   } result_type;

endpackage

// ===== hdl/motion_tamper_alarm_detector.sv =====
// ----------------------------------------------------------------------------
// motion_tamper_alarm_detector
// Per wake period: sample window, tamper detection, alarm and packet fields.
// ----------------------------------------------------------------------------
// Each word on the req_ channel is one wake period: a three-axis accelerometer
// sample and whether the last transmission was acknowledged. Each accepted
// word yields exactly one rsp_ word with the packet fields, acknowledge
// outcome, alarm beep, warm-up completion, sleep class and alarm count.
// The csr_ channel writes the four registers by index; it is always ready
// and must only be used while no word is in flight.
// An accepted word lands in the input register; once the result register is
// free or being emptied, the window update, the divide-by-depth mean check
// and the counter logic run in one pass and the result register is loaded,
// raising rsp_valid. One word per cycle is sustained while the receiver
// takes each result; the window and counter update logic runs in one pass
// per word.
// When the receiver stalls, the result waits in its register and one more
// word may wait in the input register; req_ready drops only when both are
// full. Reset clears the window, sums and counters and restores the
// register defaults; it takes effect at the next clock edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "motion_tamper_alarm_detector_assert.svh"

module motion_tamper_alarm_detector
   import mtad_pkg::*;
#(
   parameter int WINDOW_DEPTH = 10,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  logic                          req_tx_acked,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SEQ_BITS-1:0]           rsp_packet_seq,
   output logic [COUNT_BITS-1:0]         rsp_packet_moving,
   output logic                          rsp_use_alarm_address,
   output logic [1:0]                    rsp_ack_outcome,
   output logic                          rsp_alarm_beep,
   output logic                          rsp_warmup_done,
   output logic [1:0]                    rsp_sleep_kind,
   output logic [COUNT_BITS-1:0]         rsp_alarm_count,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   // Input register holding one accepted word.
   logic                          in_valid_ff;
   logic signed [SAMPLE_BITS-1:0] in_sample_ff [3];
   logic                          in_acked_ff;

   logic           advance;
   cfg_type        cfg_ff;
   win_status_type status;
   result_type     result_c;
   result_type     rsp_ff;
   logic           rsp_valid_ff;

   // The item moves into the result register whenever that register is free
   // or is being emptied in the same cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff[0] <= req_accel_x;
         in_sample_ff[1] <= req_accel_y;
         in_sample_ff[2] <= req_accel_z;
         in_acked_ff     <= req_tx_acked;
      end
   end

   // Register file; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motion_threshold <= THRESH_BITS'(8);
         cfg_ff.loss_limit       <= LIMIT_BITS'(4);
         cfg_ff.moving_limit     <= LIMIT_BITS'(4);
         cfg_ff.alarm_beep_limit <= LIMIT_BITS'(8);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MOTION_THRESHOLD: begin
               cfg_ff.motion_threshold <= csr_data[THRESH_BITS-1:0];
            end
            CSR_LOSS_LIMIT: begin
               cfg_ff.loss_limit <= csr_data[LIMIT_BITS-1:0];
            end
            CSR_MOVING_LIMIT: begin
               cfg_ff.moving_limit <= csr_data[LIMIT_BITS-1:0];
            end
            CSR_ALARM_BEEP_LIMIT: begin
               cfg_ff.alarm_beep_limit <= csr_data[LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   mtad_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_window (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .sample           (in_sample_ff),
      .motion_threshold (cfg_ff.motion_threshold),
      .status           (status)
   );

   mtad_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .tx_acked (in_acked_ff),
      .cfg      (cfg_ff),
      .status   (status),
      .result   (result_c)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_c;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_packet_seq        = rsp_ff.packet_seq;
   assign rsp_packet_moving     = rsp_ff.packet_moving;
   assign rsp_use_alarm_address = rsp_ff.use_alarm_address;
   assign rsp_ack_outcome       = rsp_ff.ack_outcome;
   assign rsp_alarm_beep        = rsp_ff.alarm_beep;
   assign rsp_warmup_done       = rsp_ff.warmup_done;
   assign rsp_sleep_kind        = rsp_ff.sleep_kind;
   assign rsp_alarm_count       = rsp_ff.alarm_count;

   `MTAD_ASSERT_NEXT(a_rsp_loaded, advance, rsp_valid_ff)
   `MTAD_ASSERT_NEXT(a_in_held, in_valid_ff && rsp_valid_ff && !rsp_ready, in_valid_ff)
   `MTAD_ASSERT_ALWAYS(a_beep_tamper,
      !rsp_valid_ff || !rsp_ff.alarm_beep || rsp_ff.sleep_kind == SLEEP_TAMPER)

endmodule

// ===== hdl/mtad_div.sv =====
// ----------------------------------------------------------------------------
// mtad_div
// Signed division of a window sum by a constant depth, truncated toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtad_div #(
   parameter int SUM_BITS = 16,
   parameter int QUO_BITS = 12,
   parameter int DIVISOR  = 10
) (
   input  logic signed [SUM_BITS-1:0] dividend,
   output logic signed [QUO_BITS-1:0] quotient
);

   // Rounded-up reciprocal, exact for every magnitude of SUM_BITS bits.
   localparam int SHIFT_BITS = SUM_BITS + $clog2(DIVISOR);
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT_BITS) + DIVISOR - 1) / DIVISOR;
   localparam int PROD_BITS = 2 * SUM_BITS + 1;

   logic                  neg;
   logic [SUM_BITS-1:0]   mag;
   logic [SUM_BITS:0]     recip_c;
   logic [PROD_BITS-1:0]  prod;
   logic [QUO_BITS-1:0]   quo_mag;

   assign recip_c = RECIP[SUM_BITS:0];
   assign neg     = dividend[SUM_BITS-1];
   assign mag     = neg ? (~dividend + SUM_BITS'(1)) : dividend;
   assign prod    = PROD_BITS'(mag) * PROD_BITS'(recip_c);
   assign quo_mag = prod[SHIFT_BITS +: QUO_BITS];

   // Negating the magnitude gives truncation toward zero.
   assign quotient = neg ? $signed(~quo_mag + QUO_BITS'(1)) : $signed(quo_mag);

endmodule

// ===== hdl/mtad_window.sv =====
// ----------------------------------------------------------------------------
// mtad_window
// Sample window, running sums, fill tracking and the motion deviation check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "motion_tamper_alarm_detector_assert.svh"

module mtad_window
   import mtad_pkg::*;
#(
   parameter int WINDOW_DEPTH = 10,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic signed [SAMPLE_BITS-1:0] sample [3],
   input  logic [THRESH_BITS-1:0]        motion_threshold,
   output win_status_type                status
);

   localparam int POS_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
   localparam int DEV_BITS = SAMPLE_BITS + 1;
   localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

   logic signed [SAMPLE_BITS-1:0] win_ff [WINDOW_DEPTH][3];
   logic signed [SUM_BITS-1:0]    sum_ff [3];
   logic signed [SUM_BITS-1:0]    sum_in [3];
   logic [POS_BITS-1:0]           wr_pos_ff;
   logic [POS_BITS-1:0]           wr_pos_in;
   logic                          warmed_ff;
   logic                          wrap;
   logic signed [SAMPLE_BITS-1:0] mean [3];
   logic signed [DEV_BITS-1:0]    dev [3];
   logic [SAMPLE_BITS-1:0]        dev_mag [3];
   logic [2:0]                    over;

   assign wrap      = (wr_pos_ff == POS_BITS'(WINDOW_DEPTH - 1));
   assign wr_pos_in = wrap ? '0 : wr_pos_ff + POS_BITS'(1);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = sum_ff[a] + SUM_BITS'(sample[a]) - SUM_BITS'(win_ff[wr_pos_ff][a]);
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      mtad_div #(
         .SUM_BITS (SUM_BITS),
         .QUO_BITS (SAMPLE_BITS),
         .DIVISOR  (WINDOW_DEPTH)
      ) u_div (
         .dividend (sum_in[g]),
         .quotient (mean[g])
      );
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dev[a]     = DEV_BITS'(mean[a]) - DEV_BITS'(sample[a]);
         dev_mag[a] = dev[a][DEV_BITS-1] ? SAMPLE_BITS'(-dev[a]) : SAMPLE_BITS'(dev[a]);
         over[a]    = (CMP_BITS'(dev_mag[a]) >= CMP_BITS'(motion_threshold));
      end
   end

   // Motion is only checked once the window was already full before this sample.
   assign status.skip        = !warmed_ff && !wrap;
   assign status.warmup_done = !warmed_ff && wrap;
   assign status.motion      = warmed_ff && (|over);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         warmed_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
         end
         for (int e = 0; e < WINDOW_DEPTH; e++) begin
            for (int a = 0; a < 3; a++) begin
               win_ff[e][a] <= '0;
            end
         end
      end else if (advance) begin
         wr_pos_ff <= wr_pos_in;
         if (wrap) begin
            warmed_ff <= 1'b1;
         end
         for (int a = 0; a < 3; a++) begin
            sum_ff[a]            <= sum_in[a];
            win_ff[wr_pos_ff][a] <= sample[a];
         end
      end
   end

   `MTAD_ASSERT_ALWAYS(a_pos_range, wr_pos_ff <= POS_BITS'(WINDOW_DEPTH - 1))
   `MTAD_ASSERT_NEXT(a_warm_set, advance && status.warmup_done, warmed_ff)

endmodule

// ===== hdl/mtad_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtad_ctrl
// Sequence, acknowledge, loss, tamper, moving and alarm counters per period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtad_ctrl
   import mtad_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           tx_acked,
   input  cfg_type        cfg,
   input  win_status_type status,
   output result_type     result
);

   logic [SEQ_BITS-1:0]    seq_ff, seq_in;
   logic [TAMPER_BITS-1:0] tamper_ff, tamper_in;
   logic [COUNT_BITS-1:0]  moving_ff, moving_in;
   logic [COUNT_BITS-1:0]  loss_ff, loss_in;
   logic [COUNT_BITS-1:0]  alarm_ff, alarm_in;
   logic                   off_ff, off_in;

   always_comb begin
      seq_in    = seq_ff + SEQ_BITS'(1);
      tamper_in = tamper_ff;
      moving_in = moving_ff;
      loss_in   = loss_ff;
      alarm_in  = alarm_ff;
      off_in    = off_ff;

      result.packet_seq        = seq_ff;
      result.packet_moving     = moving_ff;
      result.use_alarm_address = (alarm_ff != '0) && seq_in[0];
      result.ack_outcome       = ACK_NONE;
      result.alarm_beep        = 1'b0;
      result.warmup_done       = status.warmup_done;
      result.sleep_kind        = SLEEP_WARMUP;

      if (tx_acked) begin
         if (alarm_ff != '0) begin
            result.ack_outcome = seq_in[0] ? ACK_ALARM : ACK_BROADCAST;
            alarm_in           = '0;
         end
         tamper_in = '0;
         moving_in = '0;
         loss_in   = '0;
         off_in    = 1'b0;
      end else if (!off_ff) begin
         if (loss_ff < cfg.loss_limit) begin
            loss_in = loss_ff + COUNT_BITS'(1);
         end else begin
            tamper_in = TAMPER_RELOAD;
         end
      end

      // Unfilled warm-up periods skip the motion check and tamper countdown.
      if (!status.skip) begin
         if (status.motion) begin
            tamper_in = TAMPER_RELOAD;
         end
         if ((tamper_in != '0) && !off_in) begin
            result.sleep_kind = SLEEP_TAMPER;
            tamper_in         = tamper_in - TAMPER_BITS'(1);
            if (moving_in < cfg.moving_limit) begin
               moving_in = moving_in + COUNT_BITS'(1);
            end else begin
               result.alarm_beep = 1'b1;
               if ((alarm_in <= cfg.alarm_beep_limit) && (alarm_in != COUNT_MAX)) begin
                  alarm_in = alarm_in + COUNT_BITS'(1);
               end else begin
                  off_in = 1'b1;
               end
            end
         end else begin
            result.sleep_kind = (loss_in != '0) ? SLEEP_LOSS : SLEEP_IDLE;
            moving_in         = '0;
         end
      end

      result.alarm_count = alarm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= '0;
         tamper_ff <= '0;
         moving_ff <= '0;
         loss_ff   <= '0;
         alarm_ff  <= '0;
         off_ff    <= 1'b0;
      end else if (advance) begin
         seq_ff    <= seq_in;
         tamper_ff <= tamper_in;
         moving_ff <= moving_in;
         loss_ff   <= loss_in;
         alarm_ff  <= alarm_in;
         off_ff    <= off_in;
      end
   end

endmodule
